// ===== design/omni_pkg.sv =====
// Shared types, constants and the sine table builder for the omni wheel mixer.
// Used by omni_trig, omni_div and omni_wheel_speed_mixer_core.
// No dependencies.
package omni_pkg;

  // Port widths
  localparam int SpeedW   = 7;
  localparam int HeadingW = 9;
  localparam int SpinW    = 8;
  localparam int LimitW   = 8;
  localparam int WheelW   = 8;
  localparam int MaskW    = 4;
  localparam int NumWheels = 4;

  // Saturated limit and quotient width (quotient never exceeds the limit)
  localparam int LimitMax = 127;
  localparam int QuotW    = 7;

  // Angle constants in whole degrees
  localparam int HeadingOffset = 45;
  localparam int QuarterTurn   = 90;
  localparam int HalfTurn      = 180;
  localparam int ThreeQuarter  = 270;
  localparam int FullTurn      = 360;
  localparam int AngleW        = 9;   // holds 0..359

  // Quarter-wave sine table: sin(k deg), k = 0..90
  localparam int SinEntries = 91;
  localparam int SinIdxW    = 7;
  localparam int FracMax    = 20;
  localparam int SinEntryW  = FracMax + 1;

  // pi/180 in Q30, truncated
  localparam longint unsigned DegToRadQ30 = 64'd18740330;

  // Taylor series divisors (n+1)(n+2) for n = 1, 3, ..., 11
  localparam int TaylorTerms = 6;
  localparam int unsigned TaylorDiv [TaylorTerms] = '{6, 20, 42, 72, 110, 156};

  typedef logic [SinEntries*SinEntryW-1:0] sin_tab_t;

  // Side data that rides along a divider lane
  typedef struct packed {
    logic             scale;  // use quotient, else the truncated raw value
    logic             neg;    // raw wheel was negative
    logic [QuotW-1:0] alt;    // |W| >> frac, used when not scaling
  } lane_ctl_t;

  // Builds the sine table at elaboration: series in Q30, clamped,
  // then rounded half up to Q(frac). Entry k sits at bits k*SinEntryW.
  function automatic sin_tab_t sin_table(input int unsigned frac);
    sin_tab_t         tab;
    longint unsigned  x;
    longint unsigned  x2;
    longint unsigned  term;
    longint           sum;
    tab = '0;
    for (int unsigned k = 0; k < SinEntries; k++) begin
      x    = 64'(k) * DegToRadQ30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int j = 0; j < TaylorTerms; j++) begin
        term = ((term * x2) >> 30) / TaylorDiv[j];
        if (j[0]) begin
          sum = sum + longint'(term);
        end else begin
          sum = sum - longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (longint'(1) << 30)) begin
        sum = longint'(1) << 30;
      end
      sum = (sum + (longint'(1) << (29 - frac))) >>> (30 - frac);
      tab[k*SinEntryW +: SinEntryW] = SinEntryW'(sum);
    end
    return tab;
  endfunction

endpackage

// ===== design/omni_trig.sv =====
// Two-stage sine/cosine unit: wraps heading-45 into 0..359, then reads the
// quarter-wave table with quadrant symmetry. Depends on omni_pkg.
// Output is signed Q(FRAC).
module omni_trig #(
  parameter int FRAC = 14
) (
  input  logic                       clk,
  input  logic signed [omni_pkg::HeadingW-1:0] heading_i,
  output logic signed [FRAC+1:0]     sin_o,
  output logic signed [FRAC+1:0]     cos_o
);

  localparam omni_pkg::sin_tab_t SinTab = omni_pkg::sin_table(FRAC);
  localparam int AW = omni_pkg::AngleW;

  typedef struct packed {
    logic                           neg;
    logic [omni_pkg::SinIdxW-1:0]   idx;
  } sin_sel_t;

  // Quadrant fold of an angle in 0..359
  function automatic sin_sel_t fold(input logic [AW-1:0] a);
    sin_sel_t sel;
    if (a <= AW'(omni_pkg::QuarterTurn)) begin
      sel.neg = 1'b0;
      sel.idx = omni_pkg::SinIdxW'(a);
    end else if (a <= AW'(omni_pkg::HalfTurn)) begin
      sel.neg = 1'b0;
      sel.idx = omni_pkg::SinIdxW'(AW'(omni_pkg::HalfTurn) - a);
    end else if (a <= AW'(omni_pkg::ThreeQuarter)) begin
      sel.neg = 1'b1;
      sel.idx = omni_pkg::SinIdxW'(a - AW'(omni_pkg::HalfTurn));
    end else begin
      sel.neg = 1'b1;
      sel.idx = omni_pkg::SinIdxW'(10'(omni_pkg::FullTurn) - 10'(a));
    end
    return sel;
  endfunction

  // Signed table value for a folded angle
  function automatic logic signed [FRAC+1:0] lookup(input sin_sel_t sel);
    logic [omni_pkg::SinEntryW-1:0] ent;
    logic signed [FRAC+1:0]         val;
    ent = SinTab[sel.idx*omni_pkg::SinEntryW +: omni_pkg::SinEntryW];
    val = $signed({1'b0, ent[FRAC:0]});
    return sel.neg ? -val : val;
  endfunction

  logic signed [AW+1:0] d_raw;
  logic signed [AW+1:0] d_wrap;
  logic [AW-1:0]        d_nxt;
  logic [AW:0]          dc_raw;
  logic [AW-1:0]        dc_nxt;
  logic [AW-1:0]        d_r;
  logic [AW-1:0]        dc_r;
  logic signed [FRAC+1:0] sin_r;
  logic signed [FRAC+1:0] cos_r;

  // Stage A: d = heading - 45 mod 360, and d + 90 mod 360 for the cosine
  always_comb begin
    d_raw  = (AW+2)'(heading_i) - (AW+2)'(omni_pkg::HeadingOffset);
    d_wrap = d_raw[AW+1] ? d_raw + (AW+2)'(omni_pkg::FullTurn) : d_raw;
    d_nxt  = d_wrap[AW-1:0];
    dc_raw = (AW+1)'(d_nxt) + (AW+1)'(omni_pkg::QuarterTurn);
    dc_nxt = (dc_raw >= (AW+1)'(omni_pkg::FullTurn)) ?
             AW'(dc_raw - (AW+1)'(omni_pkg::FullTurn)) : dc_raw[AW-1:0];
  end

  always_ff @(posedge clk) begin
    d_r  <= d_nxt;
    dc_r <= dc_nxt;
  end

  // Stage B: table reads
  always_ff @(posedge clk) begin
    sin_r <= lookup(fold(d_r));
    cos_r <= lookup(fold(dc_r));
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

// ===== design/omni_div.sv =====
// Pipelined restoring divider lane: one quotient bit per stage, QuotW stages,
// then picks scaled or truncated value and applies the sign.
// Depends on omni_pkg (lane_ctl_t, QuotW, WheelW).
module omni_div #(
  parameter int NUM_W = 29,
  parameter int DEN_W = 22
) (
  input  logic                      clk,
  input  logic [NUM_W-1:0]          num_i,
  input  logic [DEN_W-1:0]          den_i,
  input  omni_pkg::lane_ctl_t       ctl_i,
  output logic signed [omni_pkg::WheelW-1:0] res_o
);

  localparam int QW = omni_pkg::QuotW;

  logic [NUM_W-1:0]      rem_r [QW-1];
  logic [DEN_W-1:0]      den_r [QW-1];
  logic [QW-1:0]         quo_r [QW];
  omni_pkg::lane_ctl_t   ctl_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [NUM_W-1:0]    rem_in;
    logic [DEN_W-1:0]    den_in;
    logic [QW-1:0]       quo_in;
    omni_pkg::lane_ctl_t ctl_in;
    logic [NUM_W:0]      sub;
    logic [NUM_W:0]      diff;
    logic                take;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign ctl_in = ctl_i;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
      assign ctl_in = ctl_r[i-1];
    end

    // Trial subtract of the shifted divisor
    assign sub  = (NUM_W+1)'(den_in) << (QW - 1 - i);
    assign diff = {1'b0, rem_in} - sub;
    assign take = ~diff[NUM_W];

    always_ff @(posedge clk) begin
      quo_r[i] <= take ? (quo_in | (QW'(1) << (QW - 1 - i))) : quo_in;
      ctl_r[i] <= ctl_in;
    end

    if (i < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem_r[i] <= take ? diff[NUM_W-1:0] : rem_in;
        den_r[i] <= den_in;
      end
    end
  end

  // Select and sign
  logic [QW-1:0]                       q_mag;
  logic signed [omni_pkg::WheelW-1:0]  q_val;

  always_comb begin
    q_mag = ctl_r[QW-1].scale ? quo_r[QW-1] : ctl_r[QW-1].alt;
    q_val = $signed(omni_pkg::WheelW'(q_mag));
    res_o = ctl_r[QW-1].neg ? -q_val : q_val;
  end

endmodule

// ===== design/omni_wheel_speed_mixer_core.sv =====
// Top level of the omni wheel speed mixer: X-drive inverse kinematics with
// limit scaling and per-wheel reversal. Depends on omni_pkg, omni_trig, omni_div.
//
//   Channel   Handshake              Payload
//   input     start / busy           in_move_speed, in_heading_degrees,
//                                    in_spin_rate, in_limit_value
//   result    out_valid (1 cycle)    out_wheel_front_right, _rear_right,
//                                    _rear_left, _front_left
//   config    cfg_wr_en              cfg_wr_data (reversal mask)
//
// One command per cycle while busy is low; each command passes through
// seven stages for angle, table, multiply, mix, magnitude, max and scale
// decision, seven for the restoring divider (one quotient bit each), one output.
// busy is high only during reset and the cycle after the synchronous reset
// releases. The receiver cannot stall, so the pipeline never holds.
module omni_wheel_speed_mixer_core #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [omni_pkg::SpeedW-1:0]            in_move_speed,
  input  logic signed [omni_pkg::HeadingW-1:0]   in_heading_degrees,
  input  logic signed [omni_pkg::SpinW-1:0]      in_spin_rate,
  input  logic [omni_pkg::LimitW-1:0]            in_limit_value,
  output logic                                   out_valid,
  output logic signed [omni_pkg::WheelW-1:0]     out_wheel_front_right,
  output logic signed [omni_pkg::WheelW-1:0]     out_wheel_rear_right,
  output logic signed [omni_pkg::WheelW-1:0]     out_wheel_rear_left,
  output logic signed [omni_pkg::WheelW-1:0]     out_wheel_front_left,
  input  logic                                   cfg_wr_en,
  input  logic [omni_pkg::MaskW-1:0]             cfg_wr_data
);

  localparam int SinW      = TRIG_FRAC_BITS + 2;
  localparam int ProdW     = TRIG_FRAC_BITS + 8;
  localparam int SumW      = TRIG_FRAC_BITS + 9;
  localparam int MagW      = TRIG_FRAC_BITS + 8;
  localparam int NumW      = TRIG_FRAC_BITS + 15;
  localparam int QW        = omni_pkg::QuotW;
  localparam int NW        = omni_pkg::NumWheels;
  localparam int PreStages = 7;
  localparam int PipeDepth = PreStages + QW + 1;

  logic                   busy_r;
  logic                   in_xfer;
  logic [PipeDepth-1:0]   vld_r;
  logic [omni_pkg::MaskW-1:0] rev_mask_r;

  // Control: busy during reset, valid chain, reversal register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      vld_r      <= '0;
      rev_mask_r <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[PipeDepth-2:0], in_xfer};
      if (cfg_wr_en) begin
        rev_mask_r <= cfg_wr_data;
      end
    end
  end

  assign in_xfer   = start & ~busy_r;
  assign busy      = busy_r;
  assign out_valid = vld_r[PipeDepth-1];

  // Stage A: capture command, saturate limit
  logic [QW-1:0]                     lim_sat;
  logic [omni_pkg::SpeedW-1:0]       speed_a_r;
  logic signed [omni_pkg::SpinW-1:0] spin_a_r;
  logic [QW-1:0]                     lim_a_r;

  assign lim_sat = (in_limit_value > omni_pkg::LimitW'(omni_pkg::LimitMax)) ?
                   QW'(omni_pkg::LimitMax) : in_limit_value[QW-1:0];

  always_ff @(posedge clk) begin
    speed_a_r <= in_move_speed;
    spin_a_r  <= in_spin_rate;
    lim_a_r   <= lim_sat;
  end

  // Stages A-B: sine and cosine of heading - 45
  logic signed [SinW-1:0] sin_b;
  logic signed [SinW-1:0] cos_b;

  omni_trig #(
    .FRAC (TRIG_FRAC_BITS)
  ) u_trig (
    .clk       (clk),
    .heading_i (in_heading_degrees),
    .sin_o     (sin_b),
    .cos_o     (cos_b)
  );

  // Stage B: delay command fields alongside the table read
  logic [omni_pkg::SpeedW-1:0]       speed_b_r;
  logic signed [omni_pkg::SpinW-1:0] spin_b_r;
  logic [QW-1:0]                     lim_b_r;

  always_ff @(posedge clk) begin
    speed_b_r <= speed_a_r;
    spin_b_r  <= spin_a_r;
    lim_b_r   <= lim_a_r;
  end

  // Stage C: speed*sin, speed*cos, spin in Q(frac)
  logic signed [ProdW-1:0] prod_s_r;
  logic signed [ProdW-1:0] prod_c_r;
  logic signed [SumW-1:0]  spin_c_r;
  logic [QW-1:0]           lim_c_r;

  always_ff @(posedge clk) begin
    prod_s_r <= ProdW'($signed({1'b0, speed_b_r})) * ProdW'(sin_b);
    prod_c_r <= ProdW'($signed({1'b0, speed_b_r})) * ProdW'(cos_b);
    spin_c_r <= SumW'(spin_b_r) <<< TRIG_FRAC_BITS;
    lim_c_r  <= lim_b_r;
  end

  // Stage D: raw wheel mix
  logic signed [SumW-1:0] whl_d_r [NW];
  logic [QW-1:0]          lim_d_r;

  always_ff @(posedge clk) begin
    whl_d_r[0] <= spin_c_r + SumW'(prod_s_r);
    whl_d_r[1] <= spin_c_r - SumW'(prod_c_r);
    whl_d_r[2] <= spin_c_r - SumW'(prod_s_r);
    whl_d_r[3] <= spin_c_r + SumW'(prod_c_r);
    lim_d_r    <= lim_c_r;
  end

  // Stage E: magnitudes and signs
  logic [MagW-1:0] mag_e_r [NW];
  logic [NW-1:0]   neg_e_r;
  logic [QW-1:0]   lim_e_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < NW; i++) begin
      mag_e_r[i] <= whl_d_r[i][SumW-1] ? MagW'(-whl_d_r[i]) : MagW'(whl_d_r[i]);
      neg_e_r[i] <= whl_d_r[i][SumW-1];
    end
    lim_e_r <= lim_d_r;
  end

  // Stage F: largest magnitude, |W|*L, truncated raw value, limit in Q(frac)
  logic [MagW-1:0] max_lo;
  logic [MagW-1:0] max_hi;
  logic [MagW-1:0] max_f_r;
  logic [MagW-1:0] lim_sh_f_r;
  logic [NumW-1:0] num_f_r [NW];
  logic [QW-1:0]   alt_f_r [NW];
  logic [NW-1:0]   neg_f_r;

  assign max_lo = (mag_e_r[0] > mag_e_r[1]) ? mag_e_r[0] : mag_e_r[1];
  assign max_hi = (mag_e_r[2] > mag_e_r[3]) ? mag_e_r[2] : mag_e_r[3];

  always_ff @(posedge clk) begin
    max_f_r    <= (max_lo > max_hi) ? max_lo : max_hi;
    lim_sh_f_r <= MagW'(lim_e_r) << TRIG_FRAC_BITS;
    for (int i = 0; i < NW; i++) begin
      num_f_r[i] <= NumW'(mag_e_r[i]) * NumW'(lim_e_r);
      alt_f_r[i] <= QW'(mag_e_r[i] >> TRIG_FRAC_BITS);
    end
    neg_f_r <= neg_e_r;
  end

  // Stage G: scale decision, divider operands
  logic                scale_g;
  logic [MagW-1:0]     den_g_r;
  logic [NumW-1:0]     num_g_r [NW];
  omni_pkg::lane_ctl_t ctl_g_r [NW];

  assign scale_g = max_f_r > lim_sh_f_r;

  always_ff @(posedge clk) begin
    den_g_r <= max_f_r;
    for (int i = 0; i < NW; i++) begin
      num_g_r[i]       <= num_f_r[i];
      ctl_g_r[i].scale <= scale_g;
      ctl_g_r[i].neg   <= neg_f_r[i];
      ctl_g_r[i].alt   <= alt_f_r[i];
    end
  end

  // Divider lanes, one per wheel
  logic signed [omni_pkg::WheelW-1:0] res [NW];

  for (genvar i = 0; i < NW; i++) begin : g_lane
    omni_div #(
      .NUM_W (NumW),
      .DEN_W (MagW)
    ) u_div (
      .clk   (clk),
      .num_i (num_g_r[i]),
      .den_i (den_g_r),
      .ctl_i (ctl_g_r[i]),
      .res_o (res[i])
    );
  end

  // Output register with per-wheel reversal
  logic signed [omni_pkg::WheelW-1:0] wheel_r [NW];

  always_ff @(posedge clk) begin
    for (int i = 0; i < NW; i++) begin
      wheel_r[i] <= rev_mask_r[i] ? -res[i] : res[i];
    end
  end

  assign out_wheel_front_right = wheel_r[0];
  assign out_wheel_rear_right  = wheel_r[1];
  assign out_wheel_rear_left   = wheel_r[2];
  assign out_wheel_front_left  = wheel_r[3];

endmodule

// ===== dv/omni_wheel_speed_mixer_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for omni_wheel_speed_mixer_core: a directed table of move
// commands, then random commands under several reversal masks; typed rows are scored
// by hand, the rest by a bit-exact predictor. Depends on omni_pkg and the mixer RTL.
module omni_wheel_speed_mixer_core_tb;

  localparam int TrigFracBits  = 14;
  localparam int ClkHalf       = 5;
  localparam int PipeLatency   = 15;
  localparam int WatchdogLimit = 2000;
  localparam int ItemsPerPhase = 100;

  // Wheel slots inside a result word; the same order as the mask bits
  localparam int WheelFr = 0;
  localparam int WheelRr = 1;
  localparam int WheelRl = 2;
  localparam int WheelFl = 3;

  // Kinematics constants
  localparam longint unsigned DegRadQ30 = 64'd18740330;  // pi/180 in Q30
  localparam int MoveOffsetDeg = 45;
  localparam int HalfTurnDeg   = 180;
  localparam int SatLimit      = 127;

  typedef logic [omni_pkg::NumWheels-1:0][omni_pkg::WheelW-1:0] wheel_set_t;

  typedef struct packed {
    logic [omni_pkg::SpeedW-1:0]          speed;
    logic signed [omni_pkg::HeadingW-1:0] heading;
    logic signed [omni_pkg::SpinW-1:0]    spin;
    logic [omni_pkg::LimitW-1:0]          limit;
    logic                                 typed;   // wheels below are fixed by hand
    wheel_set_t                           wheels;
  } move_row_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 start;
  logic                                 busy;
  logic [omni_pkg::SpeedW-1:0]          in_move_speed;
  logic signed [omni_pkg::HeadingW-1:0] in_heading_degrees;
  logic signed [omni_pkg::SpinW-1:0]    in_spin_rate;
  logic [omni_pkg::LimitW-1:0]          in_limit_value;
  logic                                 out_valid;
  logic signed [omni_pkg::WheelW-1:0]   out_wheel_front_right;
  logic signed [omni_pkg::WheelW-1:0]   out_wheel_rear_right;
  logic signed [omni_pkg::WheelW-1:0]   out_wheel_rear_left;
  logic signed [omni_pkg::WheelW-1:0]   out_wheel_front_left;
  logic                                 cfg_wr_en;
  logic [omni_pkg::MaskW-1:0]           cfg_wr_data;

  wheel_set_t                 wheel_expect_q[$];
  move_row_t                  directed_rows[$];
  logic [omni_pkg::MaskW-1:0] mask_shadow;
  int                         error_count;
  int                         commands_sent;
  int                         results_checked;
  int                         masks_applied;
  int                         stall_cycles;
  string                      wheel_names[omni_pkg::NumWheels] =
                                '{"front_right", "rear_right", "rear_left", "front_left"};

  omni_wheel_speed_mixer_core #(
    .TRIG_FRAC_BITS(TrigFracBits)
  ) uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_move_speed        (in_move_speed),
    .in_heading_degrees   (in_heading_degrees),
    .in_spin_rate         (in_spin_rate),
    .in_limit_value       (in_limit_value),
    .out_valid            (out_valid),
    .out_wheel_front_right(out_wheel_front_right),
    .out_wheel_rear_right (out_wheel_rear_right),
    .out_wheel_rear_left  (out_wheel_rear_left),
    .out_wheel_front_left (out_wheel_front_left),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #ClkHalf clk = ~clk;
  end

  // sin(deg) for deg in 0..90: Q30 Taylor series, clamped, rounded half up to Q(frac)
  function automatic longint sine_quarter(input int unsigned deg);
    longint unsigned x;
    longint unsigned x_sq;
    longint unsigned term;
    longint          acc;
    x    = 64'(deg) * DegRadQ30;
    x_sq = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 11; n += 2) begin
      term = ((term * x_sq) >> 30) / 64'((n + 1) * (n + 2));
      if (((n - 1) / 2) % 2 == 0) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > (longint'(1) << 30)) begin
      acc = longint'(1) << 30;
    end
    return (acc + (longint'(1) << (29 - TrigFracBits))) >>> (30 - TrigFracBits);
  endfunction

  // sin over a full turn, deg in 0..359, by quadrant symmetry
  function automatic longint sine_turn(input int deg);
    if (deg <= 90) begin
      return sine_quarter(deg);
    end else if (deg <= HalfTurnDeg) begin
      return sine_quarter(HalfTurnDeg - deg);
    end else if (deg <= 270) begin
      return -sine_quarter(deg - HalfTurnDeg);
    end
    return -sine_quarter(360 - deg);
  endfunction

  // Wheel speeds for one move command under the given reversal mask
  function automatic wheel_set_t predict_wheels(
    input logic [omni_pkg::SpeedW-1:0]          speed,
    input logic signed [omni_pkg::HeadingW-1:0] heading,
    input logic signed [omni_pkg::SpinW-1:0]    spin,
    input logic [omni_pkg::LimitW-1:0]          limit,
    input logic [omni_pkg::MaskW-1:0]           mask
  );
    longint     raw[omni_pkg::NumWheels];
    longint     one;
    longint     sp;
    longint     rot;
    longint     s;
    longint     c;
    longint     lim;
    longint     peak;
    longint     mag;
    longint     r;
    int         d;
    wheel_set_t res;
    one = longint'(1) << TrigFracBits;
    sp  = speed;
    rot = spin;
    d   = int'(heading) - MoveOffsetDeg;
    while (d < 0) d += 360;
    while (d >= 360) d -= 360;
    s = sine_turn(d);
    c = sine_turn((d + 90) % 360);
    raw[WheelFr] = sp * s + rot * one;
    raw[WheelRr] = -sp * c + rot * one;
    raw[WheelRl] = -sp * s + rot * one;
    raw[WheelFl] = sp * c + rot * one;
    lim  = (limit > SatLimit) ? SatLimit : limit;
    peak = 0;
    for (int i = 0; i < omni_pkg::NumWheels; i++) begin
      mag = (raw[i] < 0) ? -raw[i] : raw[i];
      if (mag > peak) peak = mag;
    end
    for (int i = 0; i < omni_pkg::NumWheels; i++) begin
      if (lim == 0) begin
        r = 0;
      end else if (peak > lim * one) begin
        r = (raw[i] * lim) / peak;
      end else begin
        r = raw[i] / one;
      end
      if (mask[i]) r = -r;
      res[i] = omni_pkg::WheelW'(r);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    error_count++;
  endtask

  task automatic add_row(input int speed, input int heading, input int spin, input int limit,
                         input bit typed, input int fr = 0, input int rr = 0,
                         input int rl = 0, input int fl = 0);
    move_row_t row;
    row.speed   = omni_pkg::SpeedW'(speed);
    row.heading = omni_pkg::HeadingW'(heading);
    row.spin    = omni_pkg::SpinW'(spin);
    row.limit   = omni_pkg::LimitW'(limit);
    row.typed   = typed;
    row.wheels[WheelFr] = omni_pkg::WheelW'(fr);
    row.wheels[WheelRr] = omni_pkg::WheelW'(rr);
    row.wheels[WheelRl] = omni_pkg::WheelW'(rl);
    row.wheels[WheelFl] = omni_pkg::WheelW'(fl);
    directed_rows.push_back(row);
  endtask

  // Present one command and hold it until the transfer happens
  task automatic send_move(input move_row_t row);
    @(negedge clk);
    in_move_speed      <= row.speed;
    in_heading_degrees <= row.heading;
    in_spin_rate       <= row.spin;
    in_limit_value     <= row.limit;
    start              <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    wheel_expect_q.push_back(row.typed ? row.wheels :
      predict_wheels(row.speed, row.heading, row.spin, row.limit, mask_shadow));
    commands_sent++;
  endtask

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Stop sending and wait until every pending result has come back
  task automatic drain_results();
    hold_off(1);
    while (wheel_expect_q.size() != 0) @(posedge clk);
  endtask

  // Mask writes happen only with the pipeline empty
  task automatic write_mask(input logic [omni_pkg::MaskW-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    mask_shadow = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    masks_applied++;
  endtask

  // Result scoreboard
  always @(posedge clk) begin
    wheel_set_t seen;
    wheel_set_t want;
    if (rst_n && out_valid) begin
      seen = {out_wheel_front_left, out_wheel_rear_left, out_wheel_rear_right,
              out_wheel_front_right};
      if (wheel_expect_q.size() == 0) begin
        report_mismatch("result strobe with no command pending");
      end else begin
        want = wheel_expect_q.pop_front();
        for (int i = 0; i < omni_pkg::NumWheels; i++) begin
          if (seen[i] !== want[i]) begin
            report_mismatch($sformatf("result %0d %s: got %0d, want %0d", results_checked,
              wheel_names[i], $signed(seen[i]), $signed(want[i])));
          end
        end
        results_checked++;
      end
    end
  end

  // Watchdog: no transfer on either side for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
        $display("Timeout after %0d idle cycles", stall_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    move_row_t row;
    bit        idling;
    int        pick;
    logic [omni_pkg::MaskW-1:0] phase_masks[5];

    rst_n              = 1'b0;
    start              = 1'b0;
    in_move_speed      = '0;
    in_heading_degrees = '0;
    in_spin_rate       = '0;
    in_limit_value     = '0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    mask_shadow        = '0;
    error_count        = 0;
    commands_sent      = 0;
    results_checked    = 0;
    masks_applied      = 0;
    stall_cycles       = 0;

    // Directed table: extremes, axis headings, wrap, limit handling
    add_row(0,    0,    0,    127, 1, 0, 0, 0, 0);
    add_row(100,  45,   50,   0,   1, 0, 0, 0, 0);       // zero limit stops all
    add_row(0,    0,    -100, 0,   1, 0, 0, 0, 0);
    add_row(0,    0,    50,   127, 1, 50, 50, 50, 50);
    add_row(0,    0,    -128, 127, 1, -127, -127, -127, -127);
    add_row(0,    0,    127,  255, 1, 127, 127, 127, 127);
    add_row(100,  45,   0,    127, 1, 0, -100, 0, 100);
    add_row(100,  45,   0,    255, 1, 0, -100, 0, 100);  // limit saturates at 127
    add_row(100,  45,   0,    50,  1, 0, -50, 0, 50);
    add_row(100,  -135, 0,    127, 1, 0, 100, 0, -100);
    add_row(100,  135,  0,    127, 1, 100, 0, -100, 0);
    add_row(100,  -45,  0,    127, 1, -100, 0, 100, 0);
    add_row(127,  45,   0,    127, 1, 0, -127, 0, 127);
    add_row(127,  45,   100,  127, 0);
    add_row(100,  0,    0,    127, 0);
    add_row(100,  180,  20,   127, 0);
    add_row(100,  -180, -20,  127, 0);
    add_row(100,  255,  0,    127, 0);                   // heading at the top of its range
    add_row(100,  -256, 0,    127, 0);
    add_row(50,   30,   -30,  128, 0);
    add_row(100,  90,   100,  1,   0);
    add_row(1,    1,    -1,   127, 0);
    add_row(127,  -1,   -128, 255, 0);

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    write_mask('0);
    foreach (directed_rows[i]) begin
      send_move(directed_rows[i]);
    end

    // Random phases, one reversal mask each
    phase_masks = '{4'hF, 4'h5, 4'hA, omni_pkg::MaskW'($urandom), 4'h0};
    foreach (phase_masks[p]) begin
      write_mask(phase_masks[p]);
      idling = (p != 2);   // one phase runs back to back
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (p == 1 && i == ItemsPerPhase / 2) begin
          drain_results();
        end
        if ($urandom_range(0, 4) == 0) begin
          // raw bit patterns, out of the nominal ranges too
          row.speed   = omni_pkg::SpeedW'($urandom);
          row.heading = omni_pkg::HeadingW'($urandom);
          row.spin    = omni_pkg::SpinW'($urandom);
          row.limit   = omni_pkg::LimitW'($urandom);
        end else begin
          row.speed   = omni_pkg::SpeedW'($urandom_range(0, 100));
          row.heading = omni_pkg::HeadingW'(int'($urandom_range(0, 360)) - HalfTurnDeg);
          row.spin    = omni_pkg::SpinW'(int'($urandom_range(0, 200)) - 100);
          pick = $urandom_range(0, 9);
          if (pick == 0) begin
            row.limit = '0;
          end else if (pick == 1) begin
            row.limit = omni_pkg::LimitW'($urandom_range(128, 255));
          end else if (pick <= 3) begin
            row.limit = omni_pkg::LimitW'($urandom_range(1, 30));
          end else begin
            row.limit = omni_pkg::LimitW'($urandom_range(31, 127));
          end
        end
        row.typed  = 1'b0;
        row.wheels = '0;
        send_move(row);
        // idle gaps of random length after about one command in twenty
        if (idling && $urandom_range(0, 99) < 5) begin
          hold_off($urandom_range(1, 4));
        end
      end
    end

    drain_results();
    repeat (PipeLatency + 5) @(posedge clk);

    $display("Sent %0d move commands (%0d from the directed table) under %0d mask writes;",
             commands_sent, directed_rows.size(), masks_applied);
    $display("checked %0d wheel results, %0d mismatches.", results_checked, error_count);
    if (error_count == 0 && wheel_expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
